/* rtl/evr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evr_pkg
// Shared constants and types for the vertex Euler rotation pipeline.
// ----------------------------------------------------------------------------
package evr_pkg;

	localparam int COORD_WIDTH_DEF    = 32;
	localparam int TRIG_FRAC_BITS_DEF = 14;
	localparam int TRIG_WIDTH         = 16;
	localparam int CFG_IDX_W          = 3;

	localparam logic signed [TRIG_WIDTH-1:0] COS_RESET = 16'sd16384;
	localparam logic signed [TRIG_WIDTH-1:0] SIN_RESET = 16'sd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COS_X = 3'd0,
		CFG_SIN_X = 3'd1,
		CFG_COS_Y = 3'd2,
		CFG_SIN_Y = 3'd3,
		CFG_COS_Z = 3'd4,
		CFG_SIN_Z = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic load_mul;
		logic load_sum;
	} stage_ctl_t;

endpackage
`default_nettype wire

/* rtl/vertex_euler_rotation_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_euler_rotation_top
// Rotates a vertex about z, then y, then x, with saturating fixed point.
//
//   channel | ports                          | dir | moves
//   --------+--------------------------------+-----+--------------------------
//   in      | in_valid in_stall in_x/y/z     | in  | vertex request
//   out     | out_valid out_stall out_x/y/z  | out | rotated vertex request
//   cfg     | cfg_wr_en cfg_index cfg_data   | in  | cosine/sine register write
//
// Six register stages, two per axis (products, then sum/shift/saturate):
// one request accepted per cycle while in_stall is low.
// Each stage loads when it is empty or the stage after it moves, so a
// stalled output keeps accepting requests until all six stages are full.
// Reset clears the valid bits and sets cosines to 1.0, sines to 0.
// ----------------------------------------------------------------------------
module vertex_euler_rotation_top import evr_pkg::*; #(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire logic signed [COORD_WIDTH-1:0] in_x,
	input  wire logic signed [COORD_WIDTH-1:0] in_y,
	input  wire logic signed [COORD_WIDTH-1:0] in_z,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic signed [COORD_WIDTH-1:0]      out_x,
	output logic signed [COORD_WIDTH-1:0]      out_y,
	output logic signed [COORD_WIDTH-1:0]      out_z,
	input  wire                                cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [TRIG_WIDTH-1:0]         cfg_data
);

	localparam int DEPTH = 6;

	logic signed [TRIG_WIDTH-1:0] cos_x_q, sin_x_q, cos_y_q, sin_y_q, cos_z_q, sin_z_q;
	logic [DEPTH-1:0]             vld_q;
	logic [DEPTH:0]               ready;
	stage_ctl_t                   ctl_z, ctl_y, ctl_x;

	logic signed [COORD_WIDTH-1:0] z_a, z_b, z_t;
	logic signed [COORD_WIDTH-1:0] y_a, y_b, y_t;
	logic signed [COORD_WIDTH-1:0] x_a, x_b, x_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_x_q <= COS_RESET;
			sin_x_q <= SIN_RESET;
			cos_y_q <= COS_RESET;
			sin_y_q <= SIN_RESET;
			cos_z_q <= COS_RESET;
			sin_z_q <= SIN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_COS_X: cos_x_q <= cfg_data;
				CFG_SIN_X: sin_x_q <= cfg_data;
				CFG_COS_Y: cos_y_q <= cfg_data;
				CFG_SIN_Y: sin_y_q <= cfg_data;
				CFG_COS_Z: cos_z_q <= cfg_data;
				CFG_SIN_Z: sin_z_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// advance a stage when it is empty or its successor advances
	always_comb begin
		ready[DEPTH] = ~out_stall;
		for (int k = DEPTH - 1; k >= 0; k--) begin
			ready[k] = ~vld_q[k] | ready[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ready[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < DEPTH; k++) begin
				if (ready[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign ctl_z = '{load_mul: ready[0], load_sum: ready[1]};
	assign ctl_y = '{load_mul: ready[2], load_sum: ready[3]};
	assign ctl_x = '{load_mul: ready[4], load_sum: ready[5]};

	// about z: (x, y) rotate, z rides along
	evr_rot_stage #(
		.COORD_WIDTH    (COORD_WIDTH),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_rot_z (
		.clk     (clk),
		.ctl     (ctl_z),
		.a_in    (in_x),
		.b_in    (in_y),
		.t_in    (in_z),
		.cos_val (cos_z_q),
		.sin_val (sin_z_q),
		.a_out   (z_a),
		.b_out   (z_b),
		.t_out   (z_t)
	);

	// about y: (z, x) rotate, y rides along
	evr_rot_stage #(
		.COORD_WIDTH    (COORD_WIDTH),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_rot_y (
		.clk     (clk),
		.ctl     (ctl_y),
		.a_in    (z_t),
		.b_in    (z_a),
		.t_in    (z_b),
		.cos_val (cos_y_q),
		.sin_val (sin_y_q),
		.a_out   (y_a),
		.b_out   (y_b),
		.t_out   (y_t)
	);

	// about x: (y, z) rotate, x rides along
	evr_rot_stage #(
		.COORD_WIDTH    (COORD_WIDTH),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_rot_x (
		.clk     (clk),
		.ctl     (ctl_x),
		.a_in    (y_t),
		.b_in    (y_a),
		.t_in    (y_b),
		.cos_val (cos_x_q),
		.sin_val (sin_x_q),
		.a_out   (x_a),
		.b_out   (x_b),
		.t_out   (x_t)
	);

	assign in_stall  = ~ready[0];
	assign out_valid = vld_q[DEPTH-1];
	assign out_x     = x_t;
	assign out_y     = x_a;
	assign out_z     = x_b;

endmodule
`default_nettype wire

/* rtl/evr_rot_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evr_rot_stage
// One axis rotation over two register stages: four products, then the
// difference and sum, floor shift and saturation. A third coordinate rides
// along unchanged.
// ----------------------------------------------------------------------------
module evr_rot_stage import evr_pkg::*; #(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
	input  wire                                clk,
	input  stage_ctl_t                         ctl,
	input  wire logic signed [COORD_WIDTH-1:0] a_in,
	input  wire logic signed [COORD_WIDTH-1:0] b_in,
	input  wire logic signed [COORD_WIDTH-1:0] t_in,
	input  wire logic signed [TRIG_WIDTH-1:0]  cos_val,
	input  wire logic signed [TRIG_WIDTH-1:0]  sin_val,
	output logic signed [COORD_WIDTH-1:0]      a_out,
	output logic signed [COORD_WIDTH-1:0]      b_out,
	output logic signed [COORD_WIDTH-1:0]      t_out
);

	localparam int PW = COORD_WIDTH + TRIG_WIDTH;
	localparam int SW = PW + 1;

	logic signed [PW-1:0]          p_ac_s1, p_bs_s1, p_as_s1, p_bc_s1;
	logic signed [COORD_WIDTH-1:0] t_s1;
	logic signed [SW-1:0]          na_sum, nb_sum, na_sh, nb_sh;
	logic                          na_fit, nb_fit;
	logic signed [COORD_WIDTH-1:0] na_sat, nb_sat;
	logic signed [COORD_WIDTH-1:0] a_s2, b_s2, t_s2;

	always_ff @(posedge clk) begin
		if (ctl.load_mul) begin
			p_ac_s1 <= PW'(a_in) * PW'(cos_val);
			p_bs_s1 <= PW'(b_in) * PW'(sin_val);
			p_as_s1 <= PW'(a_in) * PW'(sin_val);
			p_bc_s1 <= PW'(b_in) * PW'(cos_val);
			t_s1    <= t_in;
		end
	end

	always_comb begin
		na_sum = SW'(p_ac_s1) - SW'(p_bs_s1);
		nb_sum = SW'(p_as_s1) + SW'(p_bc_s1);
		na_sh  = na_sum >>> TRIG_FRAC_BITS;
		nb_sh  = nb_sum >>> TRIG_FRAC_BITS;
		na_fit = (&na_sh[SW-1:COORD_WIDTH-1]) | ~(|na_sh[SW-1:COORD_WIDTH-1]);
		nb_fit = (&nb_sh[SW-1:COORD_WIDTH-1]) | ~(|nb_sh[SW-1:COORD_WIDTH-1]);
		na_sat = na_fit ? na_sh[COORD_WIDTH-1:0]
		                : {na_sh[SW-1], {(COORD_WIDTH-1){~na_sh[SW-1]}}};
		nb_sat = nb_fit ? nb_sh[COORD_WIDTH-1:0]
		                : {nb_sh[SW-1], {(COORD_WIDTH-1){~nb_sh[SW-1]}}};
	end

	always_ff @(posedge clk) begin
		if (ctl.load_sum) begin
			a_s2 <= na_sat;
			b_s2 <= nb_sat;
			t_s2 <= t_s1;
		end
	end

	assign a_out = a_s2;
	assign b_out = b_s2;
	assign t_out = t_s2;

endmodule
`default_nettype wire

/* sim/vertex_euler_rotation_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_euler_rotation_top_tb
// Streams vertices through the z-y-x Euler rotation pipeline under several
// cosine/sine settings and random stalls on both sides. Each accepted request
// is rotated by a local fixed-point predictor and compared field by field
// with the result leaving the block.
// ----------------------------------------------------------------------------
module vertex_euler_rotation_top_tb;
	import evr_pkg::*;

	typedef logic signed [COORD_WIDTH_DEF-1:0] coord_t;
	typedef logic signed [TRIG_WIDTH-1:0] trig_t;
	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
	} vertex_t;

	localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH_DEF - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	localparam coord_t COORD_TOP = coord_t'(COORD_MAX);
	localparam coord_t COORD_BOTTOM = coord_t'(COORD_MIN);
	localparam coord_t COORD_ONE = coord_t'(1) <<< 16;
	localparam trig_t TRIG_ONE = 16'sd16384;
	localparam trig_t TRIG_MINUS_ONE = -16'sd16384;
	localparam trig_t TRIG_RAW_MAX = 16'sh7FFF;
	localparam trig_t TRIG_RAW_MIN = 16'sh8000;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 230;
	localparam int SETTLE_CYCLES = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	coord_t in_x = '0;
	coord_t in_y = '0;
	coord_t in_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TRIG_WIDTH-1:0] cfg_data = '0;

	trig_t trig_shadow [0:5];
	vertex_t pending_vertices [$];
	vertex_t rotated_vertices [$];
	vertex_t next_vertex;
	vertex_t want_vertex;
	int in_idle_pct = 0;
	int out_stall_pct = 0;
	int in_idle_left = 0;
	int out_stall_left = 0;
	int mismatches = 0;

	vertex_euler_rotation_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_x(in_x),
		.in_y(in_y),
		.in_z(in_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic longint shift_and_clamp(longint sum);
		longint q;
		q = sum >>> TRIG_FRAC_BITS_DEF;
		if (q > COORD_MAX)
			return COORD_MAX;
		if (q < COORD_MIN)
			return COORD_MIN;
		return q;
	endfunction

	function automatic vertex_t rotate_zyx(coord_t x_in, coord_t y_in, coord_t z_in);
		longint x, y, z, a, b;
		longint cx, sx, cy, sy, cz, sz;
		vertex_t r;
		x = x_in;
		y = y_in;
		z = z_in;
		cx = trig_shadow[CFG_COS_X];
		sx = trig_shadow[CFG_SIN_X];
		cy = trig_shadow[CFG_COS_Y];
		sy = trig_shadow[CFG_SIN_Y];
		cz = trig_shadow[CFG_COS_Z];
		sz = trig_shadow[CFG_SIN_Z];
		a = shift_and_clamp(x * cz - y * sz);
		b = shift_and_clamp(x * sz + y * cz);
		x = a;
		y = b;
		a = shift_and_clamp(z * cy - x * sy);
		b = shift_and_clamp(z * sy + x * cy);
		z = a;
		x = b;
		a = shift_and_clamp(y * cx - z * sx);
		b = shift_and_clamp(y * sx + z * cx);
		y = a;
		z = b;
		r.x = coord_t'(x);
		r.y = coord_t'(y);
		r.z = coord_t'(z);
		return r;
	endfunction

	function automatic coord_t random_coord();
		coord_t v;
		v = coord_t'($urandom);
		case ($urandom_range(0, 9))
			0: return COORD_TOP;
			1: return COORD_BOTTOM;
			2, 3, 4: return v >>> $urandom_range(8, 20);
			default: return v;
		endcase
	endfunction

	function automatic trig_t random_trig();
		case ($urandom_range(0, 7))
			0: return TRIG_ONE;
			1: return TRIG_MINUS_ONE;
			2: return '0;
			3: return TRIG_RAW_MAX;
			4: return TRIG_RAW_MIN;
			5, 6: return trig_t'(int'($urandom_range(0, 32768)) - 16384);
			default: return trig_t'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic queue_vertex(coord_t x, coord_t y, coord_t z);
		vertex_t v;
		v.x = x;
		v.y = y;
		v.z = z;
		pending_vertices = {pending_vertices, v};
	endtask

	task automatic write_trig(logic [CFG_IDX_W-1:0] idx, trig_t value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx <= CFG_SIN_Z)
			trig_shadow[idx] = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// wait until every request has been accepted and every result checked
	task automatic settle();
		while (pending_vertices.size() != 0 || rotated_vertices.size() != 0 || in_valid)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_idle_left = 0;
		end else begin
			if (in_valid && !in_stall)
				rotated_vertices = {rotated_vertices, rotate_zyx(in_x, in_y, in_z)};
			if (!in_valid || !in_stall) begin
				if (in_idle_left > 0) begin
					in_idle_left--;
					in_valid <= 1'b0;
				end else if (pending_vertices.size() != 0 && in_idle_pct != 0
						&& $urandom_range(0, 99) < in_idle_pct) begin
					in_idle_left = $urandom_range(0, 10);
					in_valid <= 1'b0;
				end else if (pending_vertices.size() != 0) begin
					next_vertex = pending_vertices.pop_front();
					in_x <= next_vertex.x;
					in_y <= next_vertex.y;
					in_z <= next_vertex.z;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (rotated_vertices.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h %h %h", out_x, out_y, out_z));
				end else begin
					want_vertex = rotated_vertices.pop_front();
					if (out_x !== want_vertex.x)
						report_mismatch($sformatf("out_x %h, want %h", out_x, want_vertex.x));
					if (out_y !== want_vertex.y)
						report_mismatch($sformatf("out_y %h, want %h", out_y, want_vertex.y));
					if (out_z !== want_vertex.z)
						report_mismatch($sformatf("out_z %h, want %h", out_z, want_vertex.z));
				end
			end
			if (out_stall_left > 0) begin
				out_stall_left--;
				out_stall <= 1'b1;
			end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
				out_stall_left = $urandom_range(0, 10);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		trig_shadow[CFG_COS_X] = COS_RESET;
		trig_shadow[CFG_SIN_X] = SIN_RESET;
		trig_shadow[CFG_COS_Y] = COS_RESET;
		trig_shadow[CFG_SIN_Y] = SIN_RESET;
		trig_shadow[CFG_COS_Z] = COS_RESET;
		trig_shadow[CFG_SIN_Z] = SIN_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset angles: identity rotation
		queue_vertex('0, '0, '0);
		queue_vertex(COORD_TOP, COORD_BOTTOM, COORD_TOP);
		queue_vertex(COORD_BOTTOM, COORD_TOP, COORD_BOTTOM);
		queue_vertex(COORD_ONE, -COORD_ONE, coord_t'(1));
		queue_vertex(coord_t'(-1), coord_t'(1), coord_t'(-1));
		queue_vertex(coord_t'(32'h5555_5555), coord_t'(32'hAAAA_AAAA), COORD_ONE);
		settle();

		// sine and cosine both at 1.0: saturate in every stage
		write_trig(CFG_COS_X, TRIG_ONE);
		write_trig(CFG_SIN_X, TRIG_ONE);
		write_trig(CFG_COS_Y, TRIG_ONE);
		write_trig(CFG_SIN_Y, TRIG_ONE);
		write_trig(CFG_COS_Z, TRIG_ONE);
		write_trig(CFG_SIN_Z, TRIG_ONE);
		queue_vertex(COORD_TOP, COORD_TOP, COORD_TOP);
		queue_vertex(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM);
		queue_vertex(COORD_TOP, COORD_BOTTOM, '0);
		queue_vertex(COORD_BOTTOM, COORD_TOP, COORD_TOP);
		queue_vertex(COORD_ONE, COORD_ONE, -COORD_ONE);
		settle();

		// raw register extremes, beyond +-1.0, used unclamped
		write_trig(CFG_COS_X, TRIG_RAW_MIN);
		write_trig(CFG_SIN_X, TRIG_RAW_MAX);
		write_trig(CFG_COS_Y, TRIG_RAW_MAX);
		write_trig(CFG_SIN_Y, TRIG_RAW_MIN);
		write_trig(CFG_COS_Z, TRIG_RAW_MIN);
		write_trig(CFG_SIN_Z, TRIG_RAW_MIN);
		write_trig(CFG_IDX_SPARE_LO, TRIG_ONE);
		write_trig(CFG_IDX_SPARE_HI, '0);
		queue_vertex(COORD_ONE, COORD_ONE, COORD_ONE);
		queue_vertex(coord_t'(-1), coord_t'(-1), coord_t'(-1));
		queue_vertex(COORD_TOP, '0, COORD_BOTTOM);
		queue_vertex(coord_t'(12345), coord_t'(-678901), coord_t'(42));
		settle();

		for (int p = 0; p < PHASES; p++) begin
			write_trig(CFG_COS_X, random_trig());
			write_trig(CFG_SIN_X, random_trig());
			write_trig(CFG_COS_Y, random_trig());
			write_trig(CFG_SIN_Y, random_trig());
			write_trig(CFG_COS_Z, random_trig());
			write_trig(CFG_SIN_Z, random_trig());
			if ($urandom_range(0, 1))
				write_trig($urandom_range(0, 1) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI,
					trig_t'($urandom));
			if (p == PHASES - 1) begin
				in_idle_pct = 0;
				out_stall_pct = 0;
			end else begin
				in_idle_pct = (p % 4) * 10;
				out_stall_pct = ((p + 2) % 4) * 10;
			end
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				queue_vertex(random_coord(), random_coord(), random_coord());
			settle();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* files.f */
rtl/evr_pkg.sv
rtl/evr_rot_stage.sv
rtl/vertex_euler_rotation_top.sv
sim/vertex_euler_rotation_top_tb.sv
